// ===== sv/svsg_pkg.sv =====
package svsg_pkg;

    // Sine table and output scaling.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_W           = 16;
    localparam int SINE_MAG_W       = SINE_W - 1;
    localparam int PEAK_AMPLITUDE   = 500;
    localparam int OUT_W            = 10;
    localparam logic [OUT_W-1:0] MAG_MAX = OUT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [15:0] SINE_FULL = 16'd32767;

    // Gain and phase.
    localparam int GAIN_W    = 17;
    localparam int GAIN_FRAC = 16;
    localparam logic [GAIN_W-1:0] Q16_ONE = GAIN_W'(65536);
    localparam int PHASE_W   = 32;

    // Shared multiplier.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = GAIN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    // Bit where (product >> 16) >> 15 starts; 32768 approximates the 32767 scale.
    localparam int QUO_LSB = GAIN_FRAC + SINE_MAG_W;
    localparam int QUO_W   = PROD_W - QUO_LSB;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [GAIN_W-1:0]  VOLUME_RESET     = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]  ALPHA_RESET      = GAIN_W'(656);
    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = PHASE_W'(42852282);

    typedef enum logic [1:0] {
        REG_VOLUME     = 2'd0,
        REG_ALPHA      = 2'd1,
        REG_PHASE_STEP = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  volume;
        logic [GAIN_W-1:0]  alpha;
        logic [PHASE_W-1:0] phase_step;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_SQUARE = 3'd0,
        MUL_CUBE   = 3'd1,
        MUL_STEP   = 3'd2,
        MUL_MAG    = 3'd3,
        MUL_PEAK   = 3'd4
    } mul_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     mul_en;
        logic     rom_rd;
        logic     set_gain;
        logic     set_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // Sine table generation, evaluated at elaboration only.
    localparam logic [63:0] HALF_TURN_Q60    = 64'd1 << 59;
    localparam logic [63:0] QUARTER_TURN_Q60 = 64'd1 << 58;
    localparam logic [63:0] TWO_PI_Q60       = 64'h6487ED5110B4611A;
    localparam logic [63:0] TAYLOR_DIV [11] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506
    };

    typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] kk;
        logic [63:0] hi;
        logic [63:0] rem;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] mag;
        logic [SINE_W-1:0] mag16;
        logic neg;
        kk  = 64'(k) << 32;
        hi  = kk / SINE_TABLE_DEPTH;
        rem = kk % SINE_TABLE_DEPTH;
        f   = (hi << 28) + ((rem << 28) / SINE_TABLE_DEPTH);
        neg = 1'b0;
        if (f >= HALF_TURN_Q60) begin
            neg = 1'b1;
            f   = f - HALF_TURN_Q60;
        end
        if (f > QUARTER_TURN_Q60) begin
            f = HALF_TURN_Q60 - f;
        end
        x    = mul_q60(f, TWO_PI_Q60);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 11; n++) begin
            term = mul_q60(term, x2) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        mag = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        mag16 = mag[SINE_W-1:0];
        return neg ? (SINE_W'(0) - mag16) : mag16;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

endpackage

// ===== sv/svsg_regs.sv =====
module svsg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svsg_pkg::PADDR_W-1:0]  paddr,
    input  logic [svsg_pkg::PDATA_W-1:0]  pwdata,
    output logic [svsg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output svsg_pkg::cfg_t                cfg
);
    import svsg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_VOLUME:     cfg_next.volume     = pwdata[GAIN_W-1:0];
                REG_ALPHA:      cfg_next.alpha      = pwdata[GAIN_W-1:0];
                REG_PHASE_STEP: cfg_next.phase_step = pwdata[PHASE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_VOLUME:     prdata = PDATA_W'(cfg_reg.volume);
            REG_ALPHA:      prdata = PDATA_W'(cfg_reg.alpha);
            REG_PHASE_STEP: prdata = PDATA_W'(cfg_reg.phase_step);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.volume     <= VOLUME_RESET;
            cfg_reg.alpha      <= ALPHA_RESET;
            cfg_reg.phase_step <= PHASE_STEP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/svsg_ctrl.sv =====
module svsg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_frame_tick,
    output logic              s_ready,
    input  svsg_pkg::status_t status,
    output svsg_pkg::cmd_t    cmd
);
    import svsg_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SQUARE = 8'b0000_0010,
        S_CUBE   = 8'b0000_0100,
        S_STEP   = 8'b0000_1000,
        S_GAIN   = 8'b0001_0000,
        S_MAG    = 8'b0010_0000,
        S_PEAK   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd.mul_sel  = MUL_SQUARE;
        cmd.mul_en   = 1'b0;
        cmd.rom_rd   = 1'b0;
        cmd.set_gain = 1'b0;
        cmd.set_out  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // A beat with the tick low is taken and dropped.
                if (s_valid && s_frame_tick) begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: begin
                cmd.mul_sel = MUL_SQUARE;
                cmd.mul_en  = 1'b1;
                cmd.rom_rd  = 1'b1;
                state_next  = S_CUBE;
            end
            S_CUBE: begin
                cmd.mul_sel = MUL_CUBE;
                cmd.mul_en  = 1'b1;
                state_next  = S_STEP;
            end
            S_STEP: begin
                cmd.mul_sel = MUL_STEP;
                cmd.mul_en  = 1'b1;
                state_next  = S_GAIN;
            end
            S_GAIN: begin
                cmd.set_gain = 1'b1;
                state_next   = S_MAG;
            end
            S_MAG: begin
                cmd.mul_sel = MUL_MAG;
                cmd.mul_en  = 1'b1;
                state_next  = S_PEAK;
            end
            S_PEAK: begin
                cmd.mul_sel = MUL_PEAK;
                cmd.mul_en  = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.set_out = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/svsg_dp.sv =====
module svsg_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  svsg_pkg::cfg_t                     cfg,
    input  svsg_pkg::cmd_t                     cmd,
    output svsg_pkg::status_t                  status,
    input  logic                               m_ready,
    output logic                               m_valid,
    output logic signed [svsg_pkg::OUT_W-1:0]  m_left_sample,
    output logic signed [svsg_pkg::OUT_W-1:0]  m_right_sample
);
    import svsg_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [PHASE_W-1:0]      phase_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic [GAIN_W-1:0]       gain_next;
    logic                    up_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic signed [SINE_W-1:0] rom_data_reg;
    logic [OUT_W-1:0]        out_reg;
    logic [OUT_W-1:0]        out_next;
    logic                    out_valid_reg;

    logic [GAIN_W-1:0]       vol_sat;
    logic [GAIN_W-1:0]       alpha_sat;
    logic [GAIN_W-1:0]       prod_q16;
    logic                    up_now;
    logic [GAIN_W-1:0]       diff;
    logic [SINE_W-1:0]       sine_abs;
    logic                    sine_neg;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       prod;
    logic [QUO_W-1:0]        quo_est;
    logic [15:0]             rem_est;
    logic [OUT_W-1:0]        mag;

    assign vol_sat   = (cfg.volume > Q16_ONE) ? Q16_ONE : cfg.volume;
    assign alpha_sat = (cfg.alpha > Q16_ONE) ? Q16_ONE : cfg.alpha;

    // Product >> 16: the squared volume, the target gain or the smoothing delta.
    assign prod_q16 = prod_reg[GAIN_FRAC +: GAIN_W];

    assign up_now = (prod_q16 >= gain_reg);
    assign diff   = up_now ? (prod_q16 - gain_reg) : (gain_reg - prod_q16);

    assign sine_neg = rom_data_reg[SINE_W-1];
    assign sine_abs = sine_neg ? (SINE_W'(0) - SINE_W'(rom_data_reg)) : SINE_W'(rom_data_reg);

    always_comb begin
        case (cmd.mul_sel)
            MUL_SQUARE: begin
                mul_a = MUL_A_W'(vol_sat);
                mul_b = vol_sat;
            end
            MUL_CUBE: begin
                mul_a = MUL_A_W'(prod_q16);
                mul_b = vol_sat;
            end
            MUL_STEP: begin
                mul_a = MUL_A_W'(diff);
                mul_b = alpha_sat;
            end
            MUL_MAG: begin
                mul_a = MUL_A_W'(sine_abs[SINE_MAG_W-1:0]);
                mul_b = gain_reg;
            end
            MUL_PEAK: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(PEAK_AMPLITUDE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign gain_next = up_reg ? (gain_reg + prod_q16) : (gain_reg - prod_q16);

    // Divide by 32767 * 65536: shift by 16 + 15 gives a quotient at most one low,
    // and one compare of the remainder fixes it while the quotient is below the limit.
    assign quo_est = prod_reg[PROD_W-1:QUO_LSB];
    assign rem_est = 16'(prod_reg[QUO_LSB-1:GAIN_FRAC]) + 16'(quo_est[OUT_W-2:0]);

    always_comb begin
        if (quo_est >= QUO_W'(MAG_MAX)) begin
            mag = MAG_MAX;
        end else begin
            mag = quo_est[OUT_W-1:0] + OUT_W'(rem_est >= SINE_FULL);
        end
        out_next = sine_neg ? (OUT_W'(0) - mag) : mag;
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_left_sample   = out_reg;
    assign m_right_sample  = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rom_rd) begin
            rom_data_reg <= SINE_ROM[phase_reg[PHASE_W-1 -: SINE_ADDR_W]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod;
        end
        if (cmd.mul_en && (cmd.mul_sel == MUL_STEP)) begin
            up_reg <= up_now;
        end
        if (cmd.set_out) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.set_gain) begin
                gain_reg <= gain_next;
            end
            if (cmd.set_out) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_reg + cfg.phase_step;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/smoothed_volume_sine_generator_core.sv =====
// Sine generator with smoothed volume. Every accepted beat with frame_tick set
// produces one stereo frame, the same sample on left and right: the gain first
// moves one one-pole step toward the cube of the volume register, then the sine
// table entry picked by the top bits of the phase accumulator is scaled by that
// gain and the peak amplitude, and the phase advances by phase_step. A beat with
// frame_tick low is taken and produces nothing. Each frame is worked by one shared
// 32x17 multiplier that is used five times in sequence per frame, plus the
// registered sine ROM read, and a new beat is taken only once the controller is
// back in idle.
// The result sits in an output register, so the next tick is accepted while it
// waits; that next frame then holds in its last step until the result is taken.
// Registers on the APB port: volume at 0x0, smoothing alpha at 0x4, phase step
// at 0x8. Write them only while no frame is in progress.
module smoothed_volume_sine_generator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [svsg_pkg::PADDR_W-1:0]       paddr,
    input  logic [svsg_pkg::PDATA_W-1:0]       pwdata,
    output logic [svsg_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_frame_tick,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [svsg_pkg::OUT_W-1:0]  m_left_sample,
    output logic signed [svsg_pkg::OUT_W-1:0]  m_right_sample
);
    import svsg_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    svsg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    svsg_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_frame_tick (s_frame_tick),
        .s_ready      (s_ready),
        .status       (status),
        .cmd          (cmd)
    );

    svsg_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_left_sample  (m_left_sample),
        .m_right_sample (m_right_sample)
    );

    // A new result appears only when the controller loads the output register.
    a_result_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.set_out))
        else $error("result beat appeared without an output load");

    // The output register is never overwritten while it still holds an untaken beat.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_out |-> (!m_valid || m_ready))
        else $error("output register loaded over a pending result beat");

    // The input side is open only while the datapath is not working on a frame.
    a_ready_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!cmd.mul_en && !cmd.set_gain && !cmd.set_out))
        else $error("input ready while a frame is in progress");

endmodule
